@@ sv/ttb_pkg.sv @@
// Package for the triangle tangent basis block: widths, the triangle record
// passed from front to back, queue status and the back-end state type.
// No dependencies.
package ttb_pkg;

	localparam int IN_W   = 16;             // input field width
	localparam int EW     = IN_W + 1;       // exact edge / uv delta width
	localparam int PW     = 2 * EW;         // product width
	localparam int TW     = PW + 1;         // det / numerator width
	localparam int FRAC   = 21;             // num * 2^20 / det, rounded via *2
	localparam int DIVNW  = TW + FRAC + 1;  // dividend width
	localparam int DIVDW  = TW + 1;         // divisor width (2 * |det|)
	localparam int QW     = 33;             // kept quotient bits
	localparam int OW     = 32;             // result width
	localparam int CNTW   = $clog2(DIVNW);
	localparam int NTERM  = 7;              // det, then six numerators
	localparam int KW     = $clog2(NTERM);
	localparam int NRES   = 6;

	localparam logic [OW-1:0] SAT_POS = {1'b0, {(OW-1){1'b1}}};
	localparam logic [OW-1:0] SAT_NEG = {1'b1, {(OW-1){1'b0}}};

	// Term indexes
	localparam logic [KW-1:0] K_DET   = KW'(0);
	localparam logic [KW-1:0] K_TAN0  = KW'(1);
	localparam logic [KW-1:0] K_BIT0  = KW'(4);
	localparam logic [KW-1:0] K_LAST  = KW'(NTERM - 1);

	typedef struct packed {
		logic [2:0][EW-1:0] e1;
		logic [2:0][EW-1:0] e2;
		logic [EW-1:0]      d1u;
		logic [EW-1:0]      d1v;
		logic [EW-1:0]      d2u;
		logic [EW-1:0]      d2v;
	} tri_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_MUL,
		B_SUB,
		B_DIV,
		B_OUT
	} bst_t;

endpackage

@@ sv/ttb_front.sv @@
// Front end: gathers three vertices, forms edges and uv deltas on the third.
// Depends on ttb_pkg.
module ttb_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [15:0]         pos_x,
	input  logic [15:0]         pos_y,
	input  logic [15:0]         pos_z,
	input  logic [15:0]         tex_u,
	input  logic [15:0]         tex_v,
	input  ttb_pkg::qstat_t     qs,
	output logic                push,
	output ttb_pkg::tri_t       rec
);

	logic [1:0]  corner_q;
	logic [15:0] pa_q [3];
	logic [15:0] pb_q [3];
	logic [15:0] ua_q, va_q, ub_q, vb_q;
	logic [15:0] cur [3];
	logic        third;
	logic        accept;

	assign third    = corner_q[1];   // index 3 behaves like 2
	assign in_ready = !third || !qs.full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && third;

	assign cur[0] = pos_x;
	assign cur[1] = pos_y;
	assign cur[2] = pos_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_q <= 2'd0;
		end else if (accept) begin
			corner_q <= third ? 2'd0 : corner_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !third) begin
			if (!corner_q[0]) begin
				for (int k = 0; k < 3; k++) pa_q[k] <= cur[k];
				ua_q <= tex_u;
				va_q <= tex_v;
			end else begin
				for (int k = 0; k < 3; k++) pb_q[k] <= cur[k];
				ub_q <= tex_u;
				vb_q <= tex_v;
			end
		end
	end

	// sign-extended 17-bit differences, exact
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			rec.e1[k] = {pb_q[k][15], pb_q[k]} - {pa_q[k][15], pa_q[k]};
			rec.e2[k] = {cur[k][15], cur[k]} - {pb_q[k][15], pb_q[k]};
		end
		rec.d1u = {ub_q[15], ub_q} - {ua_q[15], ua_q};
		rec.d1v = {vb_q[15], vb_q} - {va_q[15], va_q};
		rec.d2u = {tex_u[15], tex_u} - {ub_q[15], ub_q};
		rec.d2v = {tex_v[15], tex_v} - {vb_q[15], vb_q};
	end

endmodule

@@ sv/ttb_queue.sv @@
// Two-entry triangle queue between front and back.
// Depends on ttb_pkg.
module ttb_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ttb_pkg::tri_t    din,
	input  logic             pop,
	output ttb_pkg::tri_t    head,
	output ttb_pkg::qstat_t  qs
);

	ttb_pkg::tri_t slot_q [2];
	logic          wp_q, rp_q;
	logic [1:0]    cnt_q;

	assign qs.full  = cnt_q[1];
	assign qs.empty = (cnt_q == 2'd0);
	assign head     = slot_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop)  rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wp_q] <= din;
	end

endmodule

@@ sv/ttb_div.sv @@
// Shared restoring divider: num * 2^20 / det as Q12.20, rounded half away
// from zero and saturated. One quotient bit per cycle. Depends on ttb_pkg.
module ttb_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic signed [ttb_pkg::TW-1:0]   num,
	input  logic signed [ttb_pkg::TW-1:0]   det,
	output logic                            done,
	output logic [ttb_pkg::OW-1:0]          quot
);

	logic                         busy_q;
	logic [ttb_pkg::CNTW-1:0]     cnt_q;
	logic [ttb_pkg::DIVNW-1:0]    n_q;
	logic [ttb_pkg::DIVDW-1:0]    d_q;
	logic [ttb_pkg::DIVDW-1:0]    rem_q;
	logic [ttb_pkg::QW-1:0]       q_q;
	logic                         ovf_q, neg_q, done_q;
	logic [ttb_pkg::OW-1:0]       quot_q;

	logic [ttb_pkg::TW-1:0]       nm, dm;
	logic [ttb_pkg::DIVDW:0]      sh;
	logic                         ge;
	logic [ttb_pkg::QW-1:0]       qf;
	logic                         of;
	logic                         last;
	logic [ttb_pkg::OW-1:0]       sat;

	assign nm = num[ttb_pkg::TW-1] ? ttb_pkg::TW'(-num) : ttb_pkg::TW'(num);
	assign dm = det[ttb_pkg::TW-1] ? ttb_pkg::TW'(-det) : ttb_pkg::TW'(det);

	assign sh   = {rem_q, n_q[ttb_pkg::DIVNW-1]};
	assign ge   = sh >= {1'b0, d_q};
	assign qf   = {q_q[ttb_pkg::QW-2:0], ge};
	assign of   = ovf_q || q_q[ttb_pkg::QW-1];
	assign last = (cnt_q == ttb_pkg::CNTW'(ttb_pkg::DIVNW - 1));

	always_comb begin
		if (!neg_q) begin
			sat = (of || qf[32] || qf[31]) ? ttb_pkg::SAT_POS : qf[31:0];
		end else begin
			sat = (of || qf[32] || (qf[31] && |qf[30:0])) ? ttb_pkg::SAT_NEG
				: ttb_pkg::OW'(-qf[31:0]);
		end
	end

	assign done = done_q;
	assign quot = quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			n_q   <= {1'b0, nm, {ttb_pkg::FRAC{1'b0}}} + ttb_pkg::DIVNW'(dm);
			d_q   <= {dm, 1'b0};
			rem_q <= '0;
			q_q   <= '0;
			ovf_q <= 1'b0;
			neg_q <= num[ttb_pkg::TW-1] ^ det[ttb_pkg::TW-1];
		end else if (busy_q) begin
			n_q   <= {n_q[ttb_pkg::DIVNW-2:0], 1'b0};
			rem_q <= ge ? ttb_pkg::DIVDW'(sh - {1'b0, d_q}) : sh[ttb_pkg::DIVDW-1:0];
			q_q   <= qf;
			ovf_q <= of;
			if (last) quot_q <= sat;
		end
	end

endmodule

@@ sv/ttb_back.sv @@
// Back end: det and numerators on two shared multipliers, six divisions on
// one divider, and the output register. Depends on ttb_pkg, ttb_div.
module ttb_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ttb_pkg::qstat_t      qs,
	input  ttb_pkg::tri_t        head,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [31:0]          tangent_x,
	output logic [31:0]          tangent_y,
	output logic [31:0]          tangent_z,
	output logic [31:0]          bitangent_x,
	output logic [31:0]          bitangent_y,
	output logic [31:0]          bitangent_z,
	output logic                 degenerate
);

	ttb_pkg::bst_t                      st_q, st_d;
	logic [ttb_pkg::KW-1:0]             k_q;
	ttb_pkg::tri_t                      rec_q;
	logic signed [ttb_pkg::PW-1:0]      pa_s1, pb_s1;
	logic signed [ttb_pkg::TW-1:0]      det_q;
	logic [ttb_pkg::OW-1:0]             res_q [ttb_pkg::NRES];
	logic                               degen_q;
	logic                               ovalid_q;
	logic [ttb_pkg::OW-1:0]             out_q [ttb_pkg::NRES];
	logic                               odegen_q;

	logic signed [ttb_pkg::EW-1:0]      ma0, ma1, mb0, mb1;
	logic [1:0]                         c;
	logic signed [ttb_pkg::TW-1:0]      term;
	logic                               div_start, div_done;
	logic [ttb_pkg::OW-1:0]             div_q;
	logic                               load_out;
	logic [ttb_pkg::KW-1:0]             ridx;

	assign term = ttb_pkg::TW'(pa_s1) - ttb_pkg::TW'(pb_s1);
	assign ridx = k_q - ttb_pkg::K_TAN0;

	// operand select per term
	always_comb begin
		c = (k_q >= ttb_pkg::K_BIT0) ? 2'(k_q - ttb_pkg::K_BIT0)
			: 2'(k_q - ttb_pkg::K_TAN0);
		if (k_q == ttb_pkg::K_DET) begin
			ma0 = $signed(rec_q.d1u); ma1 = $signed(rec_q.d2v);
			mb0 = $signed(rec_q.d2u); mb1 = $signed(rec_q.d1v);
		end else if (k_q < ttb_pkg::K_BIT0) begin
			ma0 = $signed(rec_q.d2v); ma1 = $signed(rec_q.e1[c]);
			mb0 = $signed(rec_q.d1v); mb1 = $signed(rec_q.e2[c]);
		end else begin
			ma0 = $signed(rec_q.d1u); ma1 = $signed(rec_q.e2[c]);
			mb0 = $signed(rec_q.d2u); mb1 = $signed(rec_q.e1[c]);
		end
	end

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ttb_pkg::B_IDLE: if (!qs.empty) st_d = ttb_pkg::B_MUL;
			ttb_pkg::B_MUL:  st_d = ttb_pkg::B_SUB;
			ttb_pkg::B_SUB: begin
				if (k_q != ttb_pkg::K_DET) st_d = ttb_pkg::B_DIV;
				else if (term == '0)        st_d = ttb_pkg::B_OUT;
				else                        st_d = ttb_pkg::B_MUL;
			end
			ttb_pkg::B_DIV: begin
				if (div_done) st_d = (k_q == ttb_pkg::K_LAST) ? ttb_pkg::B_OUT
					: ttb_pkg::B_MUL;
			end
			ttb_pkg::B_OUT: if (!ovalid_q || out_ready) st_d = ttb_pkg::B_IDLE;
			default: st_d = ttb_pkg::B_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		pop       = 1'b0;
		div_start = 1'b0;
		load_out  = 1'b0;
		unique case (st_q)
			ttb_pkg::B_IDLE: pop = !qs.empty;
			ttb_pkg::B_SUB:  div_start = (k_q != ttb_pkg::K_DET);
			ttb_pkg::B_OUT:  load_out = !ovalid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ttb_pkg::B_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (load_out)       ovalid_q <= 1'b1;
			else if (out_ready) ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rec_q <= head;
			k_q   <= ttb_pkg::K_DET;
		end
		if (st_q == ttb_pkg::B_MUL) begin
			pa_s1 <= ma0 * ma1;
			pb_s1 <= mb0 * mb1;
		end
		if (st_q == ttb_pkg::B_SUB && k_q == ttb_pkg::K_DET) begin
			det_q   <= term;
			degen_q <= (term == '0);
			k_q     <= ttb_pkg::K_TAN0;
			if (term == '0) begin
				for (int i = 0; i < ttb_pkg::NRES; i++) res_q[i] <= '0;
			end
		end
		if (st_q == ttb_pkg::B_DIV && div_done) begin
			res_q[ridx] <= div_q;
			k_q         <= k_q + 1'b1;
		end
		if (load_out) begin
			for (int i = 0; i < ttb_pkg::NRES; i++) out_q[i] <= res_q[i];
			odegen_q <= degen_q;
		end
	end

	ttb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (term),
		.det    (det_q),
		.done   (div_done),
		.quot   (div_q)
	);

	assign out_valid   = ovalid_q;
	assign tangent_x   = out_q[0];
	assign tangent_y   = out_q[1];
	assign tangent_z   = out_q[2];
	assign bitangent_x = out_q[3];
	assign bitangent_y = out_q[4];
	assign bitangent_z = out_q[5];
	assign degenerate  = odegen_q;

endmodule

@@ sv/triangle_tangent_basis.sv @@
// Flow: a vertex is taken each cycle unless the queue is full on a third
// vertex; a triangle's result follows its third vertex through pop, det multiply
// and subtract, then six terms of multiply, subtract and division (skipped when
// det is zero), then the output load. Throughput is set by the one shared
// bit-serial divider; two triangles queue ahead of it before the input stalls.
// Reset: arst_n clears corner count, queue pointers, sequencer and out_valid.
module triangle_tangent_basis (
	input  logic        clk,
	input  logic        arst_n,
	// vertex channel, one beat per vertex
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] pos_x,
	input  logic [15:0] pos_y,
	input  logic [15:0] pos_z,
	input  logic [15:0] tex_u,
	input  logic [15:0] tex_v,
	// result channel, one beat per triangle
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] tangent_x,
	output logic [31:0] tangent_y,
	output logic [31:0] tangent_z,
	output logic [31:0] bitangent_x,
	output logic [31:0] bitangent_y,
	output logic [31:0] bitangent_z,
	output logic        degenerate
);

	// Front: holds vertices one and two, forms exact 17-bit edges and uv
	// deltas when the third arrives, pushes one triangle record.
	ttb_pkg::tri_t   rec, head;
	ttb_pkg::qstat_t qs;
	logic            push, pop;

	ttb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.pos_z    (pos_z),
		.tex_u    (tex_u),
		.tex_v    (tex_v),
		.qs       (qs),
		.push     (push),
		.rec      (rec)
	);

	// Queue decouples vertex intake from the slow back end.
	ttb_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (rec),
		.pop    (pop),
		.head   (head),
		.qs     (qs)
	);

	// Back: det, numerators, divisions, saturation, output register. The
	// output register lets the next triangle be worked while a result waits.
	ttb_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.qs          (qs),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.tangent_x   (tangent_x),
		.tangent_y   (tangent_y),
		.tangent_z   (tangent_z),
		.bitangent_x (bitangent_x),
		.bitangent_y (bitangent_y),
		.bitangent_z (bitangent_z),
		.degenerate  (degenerate)
	);

endmodule

@@ sv/ttb_chk.sv @@
// Port-level checker for triangle_tangent_basis, bound to the top level.
// No package dependencies.
module ttb_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] tangent_x,
	input logic [31:0] tangent_y,
	input logic [31:0] tangent_z,
	input logic [31:0] bitangent_x,
	input logic [31:0] bitangent_y,
	input logic [31:0] bitangent_z,
	input logic        degenerate
);

	// stalled result beat holds: out_valid, tangent_x, bitangent_z, degenerate
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(tangent_x)
		&& $stable(bitangent_z) && $stable(degenerate))
		else $error("result beat changed while stalled");

	a_deg_tan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> tangent_x == 32'd0 && tangent_y == 32'd0
		&& tangent_z == 32'd0)
		else $error("degenerate triangle with nonzero tangent");

	a_deg_bit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> bitangent_x == 32'd0
		&& bitangent_y == 32'd0 && bitangent_z == 32'd0)
		else $error("degenerate triangle with nonzero bitangent");

endmodule

bind triangle_tangent_basis ttb_chk u_ttb_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.tangent_x   (tangent_x),
	.tangent_y   (tangent_y),
	.tangent_z   (tangent_z),
	.bitangent_x (bitangent_x),
	.bitangent_y (bitangent_y),
	.bitangent_z (bitangent_z),
	.degenerate  (degenerate)
);
